// ===== sv/msort_pkg.sv =====
// ----------------------------------------------------------------------------
// msort_pkg
// Shared types for the merge sorter: control state and cell operation codes.
// ----------------------------------------------------------------------------
`default_nettype none

package msort_pkg;

	localparam int unsigned DATA_W = 32;

	typedef enum logic {
		ST_FILL,
		ST_DRAIN
	} state_t;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_INSERT,
		OP_SHIFT
	} cell_op_t;

	typedef struct packed {
		cell_op_t                  op;
		logic signed [DATA_W-1:0]  value;
	} cell_ctrl_t;

endpackage

`default_nettype wire

// ===== sv/msort_cell.sv =====
// ----------------------------------------------------------------------------
// msort_cell
// One sorting cell: holds one value, takes part in a broadcast insertion
// and shifts toward the head of the row while draining.
// ----------------------------------------------------------------------------
`default_nettype none

module msort_cell (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire msort_pkg::cell_ctrl_t                ctrl,
	input  wire logic signed [msort_pkg::DATA_W-1:0]  prev_value,
	input  wire logic                                 prev_valid,
	input  wire logic                                 prev_take,
	input  wire logic signed [msort_pkg::DATA_W-1:0]  next_value,
	input  wire logic                                 next_valid,
	output logic signed [msort_pkg::DATA_W-1:0]       value_q,
	output logic                                      valid_q,
	output logic                                      take
);

	// strict compare keeps equal values in arrival order
	always_comb begin
		take = !valid_q || (value_q > $signed(ctrl.value));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			case (ctrl.op)
				msort_pkg::OP_INSERT: begin
					if (take) begin
						valid_q <= prev_take ? prev_valid : 1'b1;
					end
				end
				msort_pkg::OP_SHIFT: begin
					valid_q <= next_valid;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (ctrl.op)
			msort_pkg::OP_INSERT: begin
				if (take) begin
					value_q <= prev_take ? prev_value : $signed(ctrl.value);
				end
			end
			msort_pkg::OP_SHIFT: begin
				value_q <= next_value;
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== sv/merge_sorter_top.sv =====
// ----------------------------------------------------------------------------
// merge_sorter_top
// Stable ascending sorter of signed 32-bit runs built on a row of cells.
//
// Input channel (value, last_in, in_valid/in_ready): one element per item.
// Each accepted element is inserted into the sorted row as it is taken, and
// in_ready stays high while filling. Elements beyond MAX_ITEMS are
// dropped and the run's results carry overflow.
// After the item with last_in, the block drains: the head cell drives
// sorted_value and the row shifts one place per accepted result item,
// with last_out on the final one. In_ready is low while draining.
// The first result is offered the cycle after the last element is taken.
// A stall on out_ready simply holds the head cell and the row.
// Reset clears the valid bits, the element count and the overflow flag;
// the block then takes input at once.
// ----------------------------------------------------------------------------
`default_nettype none

module merge_sorter_top #(
	parameter int unsigned MAX_ITEMS = 64
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic signed [msort_pkg::DATA_W-1:0]  value,
	input  wire logic                                 last_in,
	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	output logic signed [msort_pkg::DATA_W-1:0]       sorted_value,
	output logic                                      last_out,
	output logic                                      overflow,
	output logic                                      out_valid,
	input  wire logic                                 out_ready
);

	localparam int unsigned CNT_W = $clog2(MAX_ITEMS + 1);

	msort_pkg::state_t     state_q, state_d;
	msort_pkg::cell_ctrl_t ctrl;
	logic [CNT_W-1:0]      count_q;
	logic                  overflow_q;
	logic                  in_fire, out_fire, full;

	logic signed [msort_pkg::DATA_W-1:0] cell_value [MAX_ITEMS+1];
	logic [MAX_ITEMS:0]                  cell_valid;
	logic [MAX_ITEMS-1:0]                cell_take;

	assign in_fire  = in_valid && in_ready;
	assign out_fire = out_valid && out_ready;
	assign full     = (count_q == CNT_W'(MAX_ITEMS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= msort_pkg::ST_FILL;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		out_valid  = 1'b0;
		ctrl.op    = msort_pkg::OP_HOLD;
		ctrl.value = value;
		case (state_q)
			msort_pkg::ST_FILL: begin
				in_ready = 1'b1;
				if (in_valid && !full) begin
					ctrl.op = msort_pkg::OP_INSERT;
				end
				if (in_valid && last_in) begin
					state_d = msort_pkg::ST_DRAIN;
				end
			end
			msort_pkg::ST_DRAIN: begin
				out_valid = 1'b1;
				if (out_ready) begin
					ctrl.op = msort_pkg::OP_SHIFT;
					if (last_out) begin
						state_d = msort_pkg::ST_FILL;
					end
				end
			end
			default: begin
				state_d = msort_pkg::ST_FILL;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			overflow_q <= 1'b0;
		end else if (out_fire && last_out) begin
			count_q    <= '0;
			overflow_q <= 1'b0;
		end else if (in_fire) begin
			if (full) begin
				overflow_q <= 1'b1;
			end else begin
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

	// end of row
	assign cell_value[MAX_ITEMS] = '0;
	assign cell_valid[MAX_ITEMS] = 1'b0;

	for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
		logic signed [msort_pkg::DATA_W-1:0] prev_value;
		logic                                prev_valid;
		logic                                prev_take;
		if (i == 0) begin : g_head
			assign prev_value = value;
			assign prev_valid = 1'b0;
			assign prev_take  = 1'b0;
		end else begin : g_body
			assign prev_value = cell_value[i-1];
			assign prev_valid = cell_valid[i-1];
			assign prev_take  = cell_take[i-1];
		end
		msort_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.prev_value (prev_value),
			.prev_valid (prev_valid),
			.prev_take  (prev_take),
			.next_value (cell_value[i+1]),
			.next_valid (cell_valid[i+1]),
			.value_q    (cell_value[i]),
			.valid_q    (cell_valid[i]),
			.take       (cell_take[i])
		);
	end

	assign sorted_value = cell_value[0];
	assign last_out     = !cell_valid[1];
	assign overflow     = overflow_q;

endmodule

`default_nettype wire

// ===== sv/merge_sorter_checker.sv =====
// ----------------------------------------------------------------------------
// merge_sorter_checker
// Port-level checks of the merge sorter: fill and drain phases and order.
// ----------------------------------------------------------------------------
`default_nettype none

module merge_sorter_checker (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	input  wire logic                                 in_ready,
	input  wire logic                                 last_in,
	input  wire logic signed [msort_pkg::DATA_W-1:0]  sorted_value,
	input  wire logic                                 last_out,
	input  wire logic                                 out_valid,
	input  wire logic                                 out_ready
);

	a_phase_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input taken while results pending");

	a_drain_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && last_in |=> out_valid)
		else $error("no result after last input item");

	a_fill_start: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last_out |=> in_ready && !out_valid)
		else $error("block not ready after final result");

	a_ascending: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_out |=>
			out_valid && (sorted_value >= $past(sorted_value)))
		else $error("results out of order");

endmodule

bind merge_sorter_top merge_sorter_checker u_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.last_in      (last_in),
	.sorted_value (sorted_value),
	.last_out     (last_out),
	.out_valid    (out_valid),
	.out_ready    (out_ready)
);

`default_nettype wire

// ===== bench/tb_merge_sorter_top.sv =====
// ----------------------------------------------------------------------------
// tb_merge_sorter_top
// Self-checking bench for the run sorter. Runs of signed words go in, one
// item each, and a local sorting model queues the ascending stable order that
// each run must come back in, with the final and overflow flags. Each result
// item is checked against the oldest queued one. Directed runs cover the word
// extremes, orderings, repeats and the capacity limit. Random runs follow,
// under changing sender gaps and receiver stalls.
// ----------------------------------------------------------------------------

module tb_merge_sorter_top;

	localparam int unsigned MAX_ITEMS    = 64;
	localparam int unsigned CLK_PERIOD   = 8;
	localparam int unsigned DRAIN_CYCLES = 2 * MAX_ITEMS + 16;
	localparam int unsigned LIMIT_CYCLES = 400000;

	typedef logic signed [msort_pkg::DATA_W-1:0] word_t;

	typedef struct {
		word_t value;
		logic  last;
		logic  ovf;
	} sorted_item_t;

	localparam word_t WORD_MIN = {1'b1, {(msort_pkg::DATA_W-1){1'b0}}};
	localparam word_t WORD_MAX = {1'b0, {(msort_pkg::DATA_W-1){1'b1}}};

	logic  clk;
	logic  arst_n;
	word_t value;
	logic  last_in;
	logic  in_valid;
	logic  in_ready;
	word_t sorted_value;
	logic  last_out;
	logic  overflow;
	logic  out_valid;
	logic  out_ready;

	word_t        held_values [MAX_ITEMS];
	int unsigned  held_count;
	logic         dropped_seen;
	sorted_item_t pending_sorted [$];

	int unsigned idle_pct;
	int unsigned stall_pct;
	int unsigned mismatch_count;
	int unsigned runs_sorted;
	int unsigned elements_sent;
	int unsigned overflow_runs;
	int unsigned results_checked;

	merge_sorter_top #(
		.MAX_ITEMS(MAX_ITEMS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.value(value),
		.last_in(last_in),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sorted_value(sorted_value),
		.last_out(last_out),
		.overflow(overflow),
		.out_valid(out_valid),
		.out_ready(out_ready)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	initial begin
		#(CLK_PERIOD * LIMIT_CYCLES);
		$display("Timed out with %0d sorted items outstanding", pending_sorted.size());
		$display("Mismatches found");
		$finish;
	end

	task automatic report_mismatch(input string field, input word_t expected, input word_t got);
		mismatch_count++;
		$display("MISMATCH %s: expected %0d, got %0d at %0t", field, expected, got, $realtime);
	endtask

	// stable insertion sort of the held run once its final item is taken
	task automatic take_element(input word_t v, input logic last);
		word_t ordered [MAX_ITEMS];
		word_t key;
		int    j;
		elements_sent++;
		if (held_count < MAX_ITEMS) begin
			held_values[held_count] = v;
			held_count++;
		end else begin
			dropped_seen = 1'b1;
		end
		if (last) begin
			ordered = held_values;
			for (int i = 1; i < held_count; i++) begin
				key = ordered[i];
				j = i;
				while (j > 0 && ordered[j-1] > key) begin
					ordered[j] = ordered[j-1];
					j--;
				end
				ordered[j] = key;
			end
			for (int i = 0; i < held_count; i++) begin
				pending_sorted.push_back(sorted_item_t'{ordered[i], i == held_count - 1,
					dropped_seen});
			end
			runs_sorted++;
			if (dropped_seen) begin
				overflow_runs++;
			end
			held_count = 0;
			dropped_seen = 1'b0;
		end
	endtask

	task automatic send_item(input word_t v, input logic last);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		value <= v;
		last_in <= last;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		take_element(v, last);
	endtask

	task automatic send_run(input word_t run [$]);
		foreach (run[i]) begin
			send_item(run[i], i == run.size() - 1);
		end
	endtask

	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_sorted.size() != 0) begin
			@(posedge clk);
		end
	endtask

	function automatic word_t random_word();
		case ($urandom_range(9))
			5, 6, 7: return word_t'($urandom_range(15)) - 8;
			8:       return $urandom_range(1) ? WORD_MIN : WORD_MAX;
			9:       return $urandom_range(1) ? WORD_MIN + 1 : WORD_MAX - 1;
			default: return word_t'($urandom);
		endcase
	endfunction

	task automatic send_random_run(input int unsigned len);
		for (int unsigned i = 0; i < len; i++) begin
			send_item(random_word(), i == len - 1);
		end
	endtask

	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin : result_check
		sorted_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_sorted.size() == 0) begin
				report_mismatch("unexpected item, sorted_value", 0, sorted_value);
			end else begin
				want = pending_sorted.pop_front();
				results_checked++;
				if (sorted_value !== want.value) begin
					report_mismatch("sorted_value", want.value, sorted_value);
				end
				if (last_out !== want.last) begin
					report_mismatch("last_out", word_t'(want.last), word_t'(last_out));
				end
				if (overflow !== want.ovf) begin
					report_mismatch("overflow", word_t'(want.ovf), word_t'(overflow));
				end
			end
		end
	end

	task automatic test_single_element_runs();
		word_t run [$];
		run = '{WORD_MIN};
		send_run(run);
		run = '{WORD_MAX};
		send_run(run);
		run = '{word_t'(0)};
		send_run(run);
		wait_drained();
	endtask

	task automatic test_orderings();
		word_t run [$];
		run = '{WORD_MIN, word_t'(-1), word_t'(0), WORD_MAX};
		send_run(run);
		run = '{WORD_MAX, word_t'(1), word_t'(0), word_t'(-1), WORD_MIN};
		send_run(run);
		run = '{word_t'(32'h5555_5555), word_t'(32'haaaa_aaaa)};
		send_run(run);
		wait_drained();
	endtask

	task automatic test_repeated_values();
		word_t run [$];
		run = '{word_t'(3), word_t'(-3), word_t'(3), word_t'(3), word_t'(-3), word_t'(0)};
		send_run(run);
		wait_drained();
	endtask

	// a run that fills the store and goes past it, its final item dropped
	task automatic test_capacity_overflow();
		idle_pct = 16;
		stall_pct = 16;
		send_random_run(MAX_ITEMS + 3);
		wait_drained();
	endtask

	task automatic test_random_traffic(input int unsigned idle, input int unsigned stall,
		input int unsigned item_target);
		int unsigned sent;
		int unsigned len;
		int unsigned pick;
		idle_pct = idle;
		stall_pct = stall;
		sent = 0;
		while (sent < item_target) begin
			pick = $urandom_range(99);
			if (pick < 80) begin
				len = $urandom_range(8, 1);
			end else if (pick < 96) begin
				len = $urandom_range(40, 9);
			end else begin
				len = $urandom_range(MAX_ITEMS + 4, MAX_ITEMS - 2);
			end
			if (len > item_target - sent) begin
				len = item_target - sent;
			end
			send_random_run(len);
			sent += len;
		end
		wait_drained();
	endtask

	initial begin
		arst_n = 1'b0;
		value = '0;
		last_in = 1'b0;
		in_valid = 1'b0;
		idle_pct = 0;
		stall_pct = 0;
		held_count = 0;
		dropped_seen = 1'b0;
		mismatch_count = 0;
		runs_sorted = 0;
		elements_sent = 0;
		overflow_runs = 0;
		results_checked = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_single_element_runs();
		test_orderings();
		test_repeated_values();
		test_capacity_overflow();
		test_random_traffic(0, 0, 23);
		test_random_traffic(58, 0, 23);
		test_random_traffic(0, 58, 23);
		test_random_traffic(16, 16, 23);

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sorted %0d runs from %0d elements, %0d of them past capacity",
			runs_sorted, elements_sent, overflow_runs);
		$display("Checked %0d sorted items under four gap and stall mixes", results_checked);
		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
sv/msort_pkg.sv
sv/msort_cell.sv
sv/merge_sorter_top.sv
sv/merge_sorter_checker.sv
bench/tb_merge_sorter_top.sv
